@@ design/apfx_pkg.sv @@
// ----------------------------------------------------------------------------
// apfx_pkg
// Shared types, constants and helpers of the application packet framer.
// ----------------------------------------------------------------------------
package apfx_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int IDX_W       = 4;

  localparam logic [8:0] SEQ_MOD_MAX = 9'd256;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_CTRL = 2'd1,
    CMD_BODY = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DATA_TYPE   = 3'd0,
    CFG_START_TYPE  = 3'd1,
    CFG_END_TYPE    = 3'd2,
    CFG_SIZE_TAG    = 3'd3,
    CFG_SIZE_LEN    = 3'd4,
    CFG_NAME_TAG    = 3'd5,
    CFG_SEQ_MODULUS = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_CTRL,
    JOB_BODY,
    JOB_ERR
  } job_kind_t;

  typedef struct packed {
    logic [7:0] data_type_code;
    logic [7:0] start_type_code;
    logic [7:0] end_type_code;
    logic [7:0] size_tag;
    logic [7:0] size_length_code;
    logic [7:0] name_tag;
    logic [8:0] seq_modulus;
  } cfg_regs_t;

  // One classified command, as handed from the front end to the serializer.
  typedef struct packed {
    job_kind_t   kind;
    logic        close;   // packet check byte follows this job's bytes
    logic [7:0]  lead;    // resolved type code, or the body byte
    logic [7:0]  seq;
    logic [15:0] len;
    logic [31:0] fsize;
  } job_t;

  // Index of the final byte a job produces.
  function automatic logic [IDX_W-1:0] job_last_idx(job_kind_t kind, logic close);
    logic [IDX_W-1:0] base;
    case (kind)
      JOB_DATA: base = IDX_W'(3);
      JOB_CTRL: base = IDX_W'(8);
      JOB_BODY: base = IDX_W'(0);
      default:  base = IDX_W'(0);
    endcase
    if (kind == JOB_ERR) begin
      return base;
    end
    return base + IDX_W'(close);
  endfunction

endpackage

@@ design/apfx_front.sv @@
// ----------------------------------------------------------------------------
// apfx_front
// Accepts commands, checks their order and turns each into a framing job.
// ----------------------------------------------------------------------------
module apfx_front
  import apfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_regs_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_is_end,
  input  logic [15:0] in_body_length,
  input  logic [31:0] in_file_size,
  input  logic [7:0]  in_body_byte,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] left_r, left_nxt;
  logic        in_pkt_r, in_pkt_nxt;

  logic [8:0]  m_eff;
  logic [8:0]  seq_wide;
  logic [8:0]  seq_inc;
  logic [8:0]  seq_diff;
  logic [7:0]  seq_adv;
  logic        reducing;
  logic        accept;

  // A modulus of zero or above the byte range counts as 256.
  assign m_eff    = (cfg.seq_modulus == 9'd0 || cfg.seq_modulus > SEQ_MOD_MAX) ?
                    SEQ_MOD_MAX : cfg.seq_modulus;
  assign seq_wide = {1'b0, seq_r};
  assign seq_inc  = seq_wide + 9'd1;
  assign seq_diff = seq_wide - m_eff;
  assign seq_adv  = (seq_inc == m_eff) ? 8'd0 : seq_inc[7:0];

  // After a modulus change the counter is brought below the modulus by
  // repeated subtraction before the next command is taken.
  assign reducing = (seq_wide >= m_eff);
  assign in_ready = !q_full && !reducing;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    q_job.kind  = JOB_ERR;
    q_job.close = 1'b0;
    q_job.lead  = in_body_byte;
    q_job.seq   = seq_r;
    q_job.len   = in_body_length;
    q_job.fsize = in_file_size;
    seq_nxt     = seq_r;
    left_nxt    = left_r;
    in_pkt_nxt  = in_pkt_r;

    if (in_cmd == CMD_DATA && !in_pkt_r) begin
      q_job.kind  = JOB_DATA;
      q_job.lead  = cfg.data_type_code;
      q_job.close = (in_body_length == 16'd0);
      seq_nxt     = seq_adv;
      left_nxt    = in_body_length;
      in_pkt_nxt  = (in_body_length != 16'd0);
    end else if (in_cmd == CMD_CTRL && !in_pkt_r) begin
      q_job.kind  = JOB_CTRL;
      q_job.lead  = in_is_end ? cfg.end_type_code : cfg.start_type_code;
      q_job.close = (in_body_length[7:0] == 8'd0);
      left_nxt    = {8'd0, in_body_length[7:0]};
      in_pkt_nxt  = (in_body_length[7:0] != 8'd0);
    end else if (in_cmd == CMD_BODY && in_pkt_r && left_r != 16'd0) begin
      q_job.kind  = JOB_BODY;
      q_job.close = (left_r == 16'd1);
      left_nxt    = left_r - 16'd1;
      in_pkt_nxt  = (left_r != 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= 8'd1;
      left_r   <= 16'd0;
      in_pkt_r <= 1'b0;
    end else if (reducing) begin
      seq_r <= seq_diff[7:0];
    end else if (accept) begin
      seq_r    <= seq_nxt;
      left_r   <= left_nxt;
      in_pkt_r <= in_pkt_nxt;
    end
  end

endmodule

@@ design/apfx_queue.sv @@
// ----------------------------------------------------------------------------
// apfx_queue
// Small job queue that decouples the command front end from the serializer.
// ----------------------------------------------------------------------------
module apfx_queue
  import apfx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_job = slot_r[rd_ptr_r];
  assign do_pop  = pop && valid;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ design/apfx_back.sv @@
// ----------------------------------------------------------------------------
// apfx_back
// Serializes queued jobs into packet bytes and keeps the XOR check byte.
// ----------------------------------------------------------------------------
module apfx_back
  import apfx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_packet_end,
  output logic       out_run_last,
  output logic       out_order_error
);

  logic [IDX_W-1:0] idx_r;
  logic [7:0]       acc_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             packet_end_r, run_last_r, order_error_r;

  logic [IDX_W-1:0] last_idx;
  logic             is_last, is_check, step;
  logic [7:0]       byte_sel;

  assign last_idx = job_last_idx(job.kind, job.close);
  assign is_last  = (idx_r == last_idx);
  assign is_check = job.close && is_last;
  assign step     = job_valid && (!out_valid_r || out_ready);
  assign job_pop  = step && is_last;

  always_comb begin
    byte_sel = acc_r;
    case (job.kind)
      JOB_DATA: begin
        case (idx_r)
          IDX_W'(0): byte_sel = job.lead;
          IDX_W'(1): byte_sel = job.seq;
          IDX_W'(2): byte_sel = job.len[15:8];
          IDX_W'(3): byte_sel = job.len[7:0];
          default:   byte_sel = acc_r;
        endcase
      end
      JOB_CTRL: begin
        case (idx_r)
          IDX_W'(0): byte_sel = job.lead;
          IDX_W'(1): byte_sel = cfg.size_tag;
          IDX_W'(2): byte_sel = cfg.size_length_code;
          IDX_W'(3): byte_sel = job.fsize[31:24];
          IDX_W'(4): byte_sel = job.fsize[23:16];
          IDX_W'(5): byte_sel = job.fsize[15:8];
          IDX_W'(6): byte_sel = job.fsize[7:0];
          IDX_W'(7): byte_sel = cfg.name_tag;
          IDX_W'(8): byte_sel = job.len[7:0];
          default:   byte_sel = acc_r;
        endcase
      end
      JOB_BODY: byte_sel = (idx_r == '0) ? job.lead : acc_r;
      default:  byte_sel = 8'd0;
    endcase
    if (is_check) begin
      byte_sel = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      acc_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + IDX_W'(1);
        if (job.kind != JOB_ERR) begin
          acc_r <= is_check ? 8'd0 : (acc_r ^ byte_sel);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r    <= byte_sel;
      packet_end_r  <= is_check;
      run_last_r    <= is_last;
      order_error_r <= (job.kind == JOB_ERR);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_packet_end  = packet_end_r;
  assign out_run_last    = run_last_r;
  assign out_order_error = order_error_r;

endmodule

@@ design/app_packet_framer_xor_bcc.sv @@
// ----------------------------------------------------------------------------
// app_packet_framer_xor_bcc
// Application packet framer: turns begin and body commands into a byte
// stream of data and control packets, each closed by an XOR check byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transfer contents
//   in_      slave      tdata: body_length, file_size, body_byte
//                       tuser: cmd, is_end
//   out_     master     tdata: out_byte; tlast: packet_end
//                       tuser: run_last, order_error
//   cfg_     write      one framing register per write, no read-back
//
// The output stream moves one byte per cycle while out_tready is high. A
// body byte command yields one byte (two when it closes the packet), so
// body streams run at one transfer per cycle unless the output stalls. A
// data begin yields four or five bytes and a control begin nine or ten;
// the front end keeps taking commands until the job queue fills. After a
// write to the sequence modulus, the input stalls while the sequence counter
// is reduced below the new modulus. Reset is synchronous and active low; it
// loads the register defaults and empties the queue and the output register.
//
// The front end checks command order and resolves the type code and sequence
// byte; the back end walks each job byte by byte and keeps the running XOR.
// The back end moves on only when the output register is empty or its byte is taken.
// ----------------------------------------------------------------------------
module app_packet_framer_xor_bcc
  import apfx_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] body_length, [47:16] file_size, [55:48] body_byte
  input  logic [55:0]            in_tdata,
  // [1:0] cmd, [2] is_end
  input  logic [2:0]             in_tuser,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] out_byte
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  // [0] run_last, [1] order_error
  output logic [1:0]             out_tuser
);

  cfg_regs_t cfg_r;

  // Register writes are only to be issued while the framer is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_type_code   <= 8'd1;
      cfg_r.start_type_code  <= 8'd2;
      cfg_r.end_type_code    <= 8'd3;
      cfg_r.size_tag         <= 8'd0;
      cfg_r.size_length_code <= 8'd4;
      cfg_r.name_tag         <= 8'd1;
      cfg_r.seq_modulus      <= SEQ_MOD_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_TYPE:   cfg_r.data_type_code   <= cfg_wdata[7:0];
        CFG_START_TYPE:  cfg_r.start_type_code  <= cfg_wdata[7:0];
        CFG_END_TYPE:    cfg_r.end_type_code    <= cfg_wdata[7:0];
        CFG_SIZE_TAG:    cfg_r.size_tag         <= cfg_wdata[7:0];
        CFG_SIZE_LEN:    cfg_r.size_length_code <= cfg_wdata[7:0];
        CFG_NAME_TAG:    cfg_r.name_tag         <= cfg_wdata[7:0];
        CFG_SEQ_MODULUS: cfg_r.seq_modulus      <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic q_full, q_push, q_pop, q_valid;
  job_t q_in_job, q_out_job;
  logic [1:0] out_flags_unused;

  apfx_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_cmd         (in_tuser[1:0]),
    .in_is_end      (in_tuser[2]),
    .in_body_length (in_tdata[15:0]),
    .in_file_size   (in_tdata[47:16]),
    .in_body_byte   (in_tdata[55:48]),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_in_job)
  );

  apfx_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_out_job)
  );

  apfx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job_valid       (q_valid),
    .job             (q_out_job),
    .job_pop         (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_byte        (out_tdata),
    .out_packet_end  (out_tlast),
    .out_run_last    (out_flags_unused[0]),
    .out_order_error (out_flags_unused[1])
  );

  assign out_tuser = out_flags_unused;

endmodule
